FILE: hdl/ppr_pkg.sv
// Shared widths, constants and tables for the plane point rotation pipeline.
package ppr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int STAGES      = 16;
  localparam int GUARD       = 24;
  localparam int NITER       = (STAGES < 32) ? STAGES : 32;

  localparam int OW  = SAMPLE_BITS + 1;         // result width
  localparam int QW  = SAMPLE_BITS + 1;         // point after quadrant turn
  localparam int DW  = SAMPLE_BITS + GUARD + 3; // datapath with guard bits and growth
  localparam int ZW  = 34;                      // angle, 2^32 per turn, plus headroom
  localparam int GW  = 32;                      // gain word width
  localparam int PW  = QW + GW;                 // gain product width
  localparam int RW  = DW + 1 - GUARD;          // rounded value before clamp
  localparam int TDW = ((3 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int RDW = ((2 * OW + 7) / 8) * 8;

  localparam logic [GW-1:0] GAIN_Q31 = GW'(1304065748);
  localparam int GAIN_SHIFT = 31 - GUARD;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [QW-1:0]          qpoint_t;
  typedef logic signed [DW-1:0]          coord_t;
  typedef logic signed [ZW-1:0]          zangle_t;
  typedef logic signed [OW-1:0]          result_t;

  localparam zangle_t QUARTER_TURN = zangle_t'(64'sd1 <<< 30);

  // Arctangent of 2^-i, 2^32 per full turn
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // ceil(sqrt(2) * 2^(SAMPLE_BITS-1)), evaluated at elaboration
  function automatic longint unsigned calc_bound();
    longint unsigned n;
    longint unsigned res;
    longint unsigned b;
    n   = 64'd1 << (2 * SAMPLE_BITS - 1);
    res = 64'd0;
    b   = 64'd1 << 62;
    while (b > n) begin
      b = b >> 2;
    end
    while (b != 64'd0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res + 64'd1;
  endfunction

  localparam longint unsigned BOUND = calc_bound();

endpackage

FILE: hdl/ppr_prerot.sv
// Quadrant pre-rotation and gain compensation, two register stages.
module ppr_prerot
  import ppr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    s_valid,
  output logic    s_ready,
  input  sample_t s_x,
  input  sample_t s_y,
  input  sample_t s_angle,
  output logic    m_valid,
  input  logic    m_ready,
  output coord_t  m_x,
  output coord_t  m_y,
  output zangle_t m_z
);

  logic    qv_r, qv_nxt;
  qpoint_t qx_r, qx_nxt;
  qpoint_t qy_r, qy_nxt;
  zangle_t qz_r, qz_nxt;
  logic    q_take;

  logic    gv_r, gv_nxt;
  coord_t  gx_r, gx_nxt;
  coord_t  gy_r, gy_nxt;
  zangle_t gz_r;
  logic    g_take;

  logic signed [PW-1:0] px;
  logic signed [PW-1:0] py;
  qpoint_t xe;
  qpoint_t ye;
  zangle_t z0;

  assign g_take  = !gv_r || m_ready;
  assign q_take  = !qv_r || g_take;
  assign s_ready = q_take;

  always_comb begin
    xe     = QW'(s_x);
    ye     = QW'(s_y);
    z0     = zangle_t'(s_angle) <<< (32 - SAMPLE_BITS);
    qx_nxt = xe;
    qy_nxt = ye;
    qz_nxt = z0;
    // turn by a quarter when the angle lies beyond +-90 degrees
    if (z0 > QUARTER_TURN) begin
      qx_nxt = -ye;
      qy_nxt = xe;
      qz_nxt = z0 - QUARTER_TURN;
    end else if (z0 < -QUARTER_TURN) begin
      qx_nxt = ye;
      qy_nxt = -xe;
      qz_nxt = z0 + QUARTER_TURN;
    end
  end

  always_comb begin
    qv_nxt = q_take ? s_valid : qv_r;
    gv_nxt = g_take ? qv_r : gv_r;
    px     = PW'(qx_r) * $signed({1'b0, GAIN_Q31});
    py     = PW'(qy_r) * $signed({1'b0, GAIN_Q31});
    gx_nxt = DW'(px >>> GAIN_SHIFT);
    gy_nxt = DW'(py >>> GAIN_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r <= 1'b0;
      gv_r <= 1'b0;
    end else begin
      qv_r <= qv_nxt;
      gv_r <= gv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      qx_r <= qx_nxt;
      qy_r <= qy_nxt;
      qz_r <= qz_nxt;
    end
    if (g_take) begin
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
      gz_r <= qz_r;
    end
  end

  assign m_valid = gv_r;
  assign m_x     = gx_r;
  assign m_y     = gy_r;
  assign m_z     = gz_r;

endmodule

FILE: hdl/ppr_cordic.sv
// Unrolled CORDIC micro-rotations, one register stage per iteration.
module ppr_cordic
  import ppr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    s_valid,
  output logic    s_ready,
  input  coord_t  s_x,
  input  coord_t  s_y,
  input  zangle_t s_z,
  output logic    m_valid,
  input  logic    m_ready,
  output coord_t  m_x,
  output coord_t  m_y
);

  logic    vs  [NITER+1];
  coord_t  xs  [NITER+1];
  coord_t  ys  [NITER+1];
  zangle_t zs  [NITER+1];
  logic    rdy [NITER+1];

  assign vs[0]      = s_valid;
  assign xs[0]      = s_x;
  assign ys[0]      = s_y;
  assign zs[0]      = s_z;
  assign rdy[NITER] = m_ready;
  assign s_ready    = rdy[0];

  for (genvar i = 0; i < NITER; i++) begin : g_iter
    logic    v_r;
    coord_t  x_r;
    coord_t  y_r;
    zangle_t z_r;
    logic    v_nxt;
    coord_t  x_nxt;
    coord_t  y_nxt;
    zangle_t z_nxt;
    coord_t  dx;
    coord_t  dy;
    zangle_t da;

    assign rdy[i]   = !v_r || rdy[i+1];
    assign vs[i+1]  = v_r;
    assign xs[i+1]  = x_r;
    assign ys[i+1]  = y_r;
    assign zs[i+1]  = z_r;

    always_comb begin
      v_nxt = rdy[i] ? vs[i] : v_r;
      dx    = ys[i] >>> i;
      dy    = xs[i] >>> i;
      da    = zangle_t'({2'b00, ATAN_TURNS[i]});
      // steer towards zero residual angle
      if (!zs[i][ZW-1]) begin
        x_nxt = xs[i] - dx;
        y_nxt = ys[i] + dy;
        z_nxt = zs[i] - da;
      end else begin
        x_nxt = xs[i] + dx;
        y_nxt = ys[i] - dy;
        z_nxt = zs[i] + da;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else begin
        v_r <= v_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
      end
    end
  end

  assign m_valid = vs[NITER];
  assign m_x     = xs[NITER];
  assign m_y     = ys[NITER];

endmodule

FILE: hdl/ppr_round.sv
// Round to nearest, clamp to the magnitude bound, and hold the output beat.
module ppr_round
  import ppr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    s_valid,
  output logic    s_ready,
  input  coord_t  s_x,
  input  coord_t  s_y,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t m_x,
  output result_t m_y
);

  localparam logic signed [RW-1:0] BOUND_P = RW'(BOUND);
  localparam logic signed [RW-1:0] BOUND_N = -BOUND_P;
  localparam logic signed [DW:0]   HALF    = (DW+1)'(64'd1 << (GUARD - 1));

  logic    v_r, v_nxt;
  result_t x_r, x_nxt;
  result_t y_r, y_nxt;
  logic    take;

  function automatic result_t round_clamp(input coord_t v);
    logic signed [DW:0]   s;
    logic signed [RW-1:0] r;
    s = (DW+1)'(v) + HALF;
    r = RW'(s >>> GUARD);
    if (r > BOUND_P) begin
      r = BOUND_P;
    end else if (r < BOUND_N) begin
      r = BOUND_N;
    end
    return OW'(r);
  endfunction

  assign take    = !v_r || m_ready;
  assign s_ready = take;

  always_comb begin
    v_nxt = take ? s_valid : v_r;
    x_nxt = round_clamp(s_x);
    y_nxt = round_clamp(s_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  assign m_valid = v_r;
  assign m_x     = x_r;
  assign m_y     = y_r;

endmodule

FILE: hdl/plane_point_rotation.sv
// Top level: CORDIC rotation of a point by a binary angle, streaming in and out.
//
//  channel | direction | tdata fields (low bit up)               | tuser/tlast
//  in_     | slave     | x_in[15:0], y_in[31:16], angle[47:32]     | none
//  out_    | master    | x_rotated[16:0], y_rotated[33:17], zeros  | none
//
// One beat is accepted per cycle while the output is not stalled; the stages are:
// quadrant turn, gain multiply, one register stage per micro-rotation, round.
// Every stage carries its own valid bit and loads when it is empty or its
// successor loads, so bubbles close up under a stalled output.
// Reset clears the valid bits only; the block keeps no other state.
module plane_point_rotation
  import ppr_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [TDW-1:0] in_tdata,   // x_in, y_in, angle
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [RDW-1:0] out_tdata   // x_rotated, y_rotated, zero fill
);

  logic    pr_valid, pr_ready;
  coord_t  pr_x, pr_y;
  zangle_t pr_z;

  logic    cr_valid, cr_ready;
  coord_t  cr_x, cr_y;

  result_t x_rotated, y_rotated;

  ppr_prerot u_prerot (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_x     (sample_t'(in_tdata[SAMPLE_BITS-1:0])),
    .s_y     (sample_t'(in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .s_angle (sample_t'(in_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS])),
    .m_valid (pr_valid),
    .m_ready (pr_ready),
    .m_x     (pr_x),
    .m_y     (pr_y),
    .m_z     (pr_z)
  );

  ppr_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (pr_valid),
    .s_ready (pr_ready),
    .s_x     (pr_x),
    .s_y     (pr_y),
    .s_z     (pr_z),
    .m_valid (cr_valid),
    .m_ready (cr_ready),
    .m_x     (cr_x),
    .m_y     (cr_y)
  );

  ppr_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (cr_valid),
    .s_ready (cr_ready),
    .s_x     (cr_x),
    .s_y     (cr_y),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_x     (x_rotated),
    .m_y     (y_rotated)
  );

  assign out_tdata = RDW'({y_rotated, x_rotated});

  // a free output must never hold back the input side
  a_ready_flow : assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output side is free");

  a_x_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(x_rotated) <= $signed(RW'(BOUND)) &&
                    $signed(x_rotated) >= -$signed(RW'(BOUND))))
    else $error("x_rotated beyond saturation bound");

  a_y_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(y_rotated) <= $signed(RW'(BOUND)) &&
                    $signed(y_rotated) >= -$signed(RW'(BOUND))))
    else $error("y_rotated beyond saturation bound");

endmodule
